FILE: src/otsu_pkg.sv
// Shared types and constants for the Otsu threshold engine.
// Depends on nothing; imported by otsu_mul and otsu_threshold_engine_core.
`timescale 1ns / 1ps
`default_nettype none

package otsu_pkg;

  // Configuration register indexes
  localparam logic [7:0] CFG_ADVANCED_MODE      = 8'd0;
  localparam logic [7:0] CFG_FALLBACK_THRESHOLD = 8'd1;

  // Configuration reset values
  localparam logic       ADVANCED_MODE_RST      = 1'b1;
  localparam logic [7:0] FALLBACK_THRESHOLD_RST = 8'd128;

  // Last grey level of the histogram
  localparam logic [7:0] LAST_BIN = 8'd255;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       pixel_counted;
    logic       frame_end;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] threshold;
    logic [7:0] first_pass_threshold;
    logic       frame_empty;
  } thr_out_t;

endpackage

`default_nettype wire

FILE: src/otsu_threshold_engine_core.sv
// Otsu threshold engine: masked 256-bin histogram in one synchronous RAM,
// followed by one or two exact integer Otsu sweeps. Uses otsu_pkg, otsu_mul.
//
// Usage:
//  - in channel (in_valid_i/in_ready_o, in_data_i): one pixel request per
//    cycle while a frame streams in. Masked pixels bump their bin through a
//    read-modify-write on the RAM with forwarding for repeated grey levels.
//    The count saturates at MAX_FRAME_PIXELS.
//  - On the frame_end pixel the block stops taking pixels and sweeps the RAM.
//    Each pass is a sum scan and a sweep scan over the bins; a bin that
//    splits the frame costs six serial multiplies on the shared shift-add
//    multiplier. Advanced mode runs two passes. A frame with no counted
//    pixel answers with the fallback threshold.
//  - The last sweep writes zeros back, so the histogram is clear when the
//    result appears on the out channel. The result holds until out_ready_i;
//    pixels are taken again after the result request completes.
//  - cfg channel: always ready; index 0 advanced_mode, 1 fallback_threshold,
//    other indexes ignored. Write only while idle.
//  - After reset the RAM is cleared bin by bin before the first pixel
//    is accepted; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module otsu_threshold_engine_core
  import otsu_pkg::*;
#(
  parameter int unsigned MAX_FRAME_PIXELS = 65536
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire pix_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output thr_out_t      out_data_o,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire logic [7:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int unsigned SUM_W = CNT_W + 8;
  localparam int unsigned NUM_W = CNT_W + SUM_W;
  localparam int unsigned DEN_W = 2 * CNT_W;
  localparam int unsigned SQ_W  = 2 * NUM_W;
  localparam int unsigned PRD_W = SQ_W + DEN_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_PIXELS);

  typedef enum logic [7:0] {
    ST_INIT  = 8'b0000_0001,
    ST_RUN   = 8'b0000_0010,
    ST_DRAIN = 8'b0000_0100,
    ST_RD    = 8'b0000_1000,
    ST_DAT   = 8'b0001_0000,
    ST_MST   = 8'b0010_0000,
    ST_MWT   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  typedef enum logic [2:0] {
    MS_TOT_SUMB = 3'd0,
    MS_ALL_WB   = 3'd1,
    MS_DEN      = 3'd2,
    MS_SQ       = 3'd3,
    MS_LHS      = 3'd4,
    MS_RHS      = 3'd5
  } mstep_e;

  state_e state_q, state_d;
  mstep_e step_q;

  // Histogram RAM
  logic [CNT_W-1:0] hist_mem [256];
  logic [CNT_W-1:0] mem_rdata_q;
  logic             mem_we;
  logic [7:0]       mem_waddr;
  logic [CNT_W-1:0] mem_wdata;
  logic [7:0]       mem_raddr;

  // Configuration
  logic       adv_q;
  logic [7:0] fb_q;

  // Pixel update pipeline
  logic [CNT_W-1:0] count_q;
  logic             s1_vld_q;
  logic [7:0]       s1_addr_q;
  logic             wr_vld_q;
  logic [7:0]       wr_addr_q;
  logic [CNT_W-1:0] wr_data_q;
  logic [CNT_W-1:0] s1_new;
  logic             in_acc;

  // Sweep state
  logic [7:0]       t_q;
  logic             phase_sum_q;
  logic             pass2_q;
  logic [7:0]       mg_q;
  logic [CNT_W-1:0] bsum_q;
  logic [SUM_W-1:0] sum_all_q;
  logic [CNT_W-1:0] w_b_q;
  logic [SUM_W-1:0] sum_b_q;
  logic [NUM_W-1:0] prod_a_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [SQ_W-1:0]  sq_q;
  logic [PRD_W-1:0] lhs_q;
  logic [SQ_W-1:0]  best_sq_q;
  logic [DEN_W-1:0] best_den_q;
  logic [7:0]       best_t_q;
  logic [7:0]       first_q;
  thr_out_t         out_q;

  // Bin view with the merge applied
  logic [CNT_W-1:0] hp;
  logic [CNT_W-1:0] bsum_n;
  logic [SUM_W-1:0] thp;
  logic [CNT_W-1:0] wb_n;
  logic [SUM_W-1:0] sb_n;
  logic             final_pass;
  logic             skip_bin;
  logic             next_bin;

  // Multiplier
  logic             mul_start;
  logic [PRD_W-1:0] mul_a;
  logic [NUM_W-1:0] mul_b;
  logic             mul_done;
  logic [PRD_W-1:0] mul_prod;
  logic [NUM_W-1:0] prod_b;
  logic             better;

  assign in_ready_o  = (state_q == ST_RUN);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = out_q;

  // Forward the value written last cycle when the same bin is hit again
  assign s1_new = ((wr_vld_q && (wr_addr_q == s1_addr_q)) ? wr_data_q : mem_rdata_q)
                  + CNT_W'(1);

  // Merge bins below mg_q into bin mg_q
  always_comb begin
    if (t_q < mg_q) begin
      bsum_n = bsum_q + mem_rdata_q;
      hp     = '0;
    end else if (t_q == mg_q) begin
      bsum_n = bsum_q;
      hp     = bsum_q + mem_rdata_q;
    end else begin
      bsum_n = bsum_q;
      hp     = mem_rdata_q;
    end
  end

  assign thp        = SUM_W'(t_q) * SUM_W'(hp);
  assign wb_n       = w_b_q + hp;
  assign sb_n       = sum_b_q + thp;
  assign final_pass = pass2_q || !adv_q;
  assign skip_bin   = (wb_n == '0) || (wb_n >= count_q);
  assign prod_b     = NUM_W'(mul_prod);
  assign better     = (lhs_q > mul_prod);

  // Step to the next bin after a skipped bin or the final compare
  assign next_bin = ((state_q == ST_DAT) && !phase_sum_q && skip_bin) ||
                    ((state_q == ST_MWT) && mul_done && (step_q == MS_RHS));

  // RAM port selection
  always_comb begin
    mem_raddr = (state_q == ST_RUN) ? in_data_i.pixel_value : t_q;
    mem_we    = 1'b0;
    mem_waddr = t_q;
    mem_wdata = '0;
    if (s1_vld_q) begin
      mem_we    = 1'b1;
      mem_waddr = s1_addr_q;
      mem_wdata = s1_new;
    end else if ((state_q == ST_INIT) ||
                 ((state_q == ST_DAT) && !phase_sum_q && final_pass)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= hist_mem[mem_raddr];
  end

  // Multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      MS_TOT_SUMB: begin
        mul_a = PRD_W'(count_q);
        mul_b = NUM_W'(sum_b_q);
      end
      MS_ALL_WB: begin
        mul_a = PRD_W'(sum_all_q);
        mul_b = NUM_W'(w_b_q);
      end
      MS_DEN: begin
        mul_a = PRD_W'(w_b_q);
        mul_b = NUM_W'(count_q - w_b_q);
      end
      MS_SQ: begin
        mul_a = PRD_W'(num_q);
        mul_b = num_q;
      end
      MS_LHS: begin
        mul_a = PRD_W'(sq_q);
        mul_b = NUM_W'(best_den_q);
      end
      MS_RHS: begin
        mul_a = PRD_W'(best_sq_q);
        mul_b = NUM_W'(den_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start = (state_q == ST_MST);

  otsu_mul #(
    .AW (PRD_W),
    .BW (NUM_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (t_q == LAST_BIN) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (in_acc && in_data_i.frame_end) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = (count_q == '0) ? ST_OUT : ST_RD;
      end
      ST_RD: begin
        state_d = ST_DAT;
      end
      ST_DAT: begin
        if (phase_sum_q) state_d = ST_RD;
        else if (!skip_bin) state_d = ST_MST;
      end
      ST_MST: begin
        state_d = ST_MWT;
      end
      ST_MWT: begin
        if (mul_done && (step_q != MS_RHS)) state_d = ST_MST;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_RUN;
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
    // Pass end or next bin
    if (next_bin) begin
      if (t_q != LAST_BIN || (!pass2_q && adv_q)) state_d = ST_RD;
      else state_d = ST_OUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      step_q      <= MS_TOT_SUMB;
      adv_q       <= ADVANCED_MODE_RST;
      fb_q        <= FALLBACK_THRESHOLD_RST;
      count_q     <= '0;
      s1_vld_q    <= 1'b0;
      s1_addr_q   <= '0;
      wr_vld_q    <= 1'b0;
      wr_addr_q   <= '0;
      wr_data_q   <= '0;
      t_q         <= '0;
      phase_sum_q <= 1'b0;
      pass2_q     <= 1'b0;
      mg_q        <= '0;
      bsum_q      <= '0;
      sum_all_q   <= '0;
      w_b_q       <= '0;
      sum_b_q     <= '0;
      prod_a_q    <= '0;
      num_q       <= '0;
      den_q       <= '0;
      sq_q        <= '0;
      lhs_q       <= '0;
      best_sq_q   <= '0;
      best_den_q  <= '0;
      best_t_q    <= '0;
      first_q     <= '0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;

      // Take configuration writes
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_ADVANCED_MODE) adv_q <= cfg_data_i[0];
        else if (cfg_index_i == CFG_FALLBACK_THRESHOLD) fb_q <= cfg_data_i;
      end

      // Pixel update pipeline
      wr_vld_q  <= s1_vld_q;
      wr_addr_q <= s1_addr_q;
      wr_data_q <= s1_new;
      s1_vld_q  <= in_acc && in_data_i.pixel_counted && (count_q < CNT_MAX);
      s1_addr_q <= in_data_i.pixel_value;
      if (in_acc && in_data_i.pixel_counted && (count_q < CNT_MAX)) begin
        count_q <= count_q + CNT_W'(1);
      end

      case (state_q)
        ST_INIT: begin
          t_q <= t_q + 8'd1;
        end
        ST_DRAIN: begin
          t_q         <= '0;
          phase_sum_q <= 1'b1;
          pass2_q     <= 1'b0;
          mg_q        <= '0;
          bsum_q      <= '0;
          sum_all_q   <= '0;
          if (count_q == '0) begin
            out_q.threshold            <= fb_q;
            out_q.first_pass_threshold <= fb_q;
            out_q.frame_empty          <= 1'b1;
          end
        end
        ST_DAT: begin
          bsum_q <= bsum_n;
          if (phase_sum_q) begin
            // Total weighted sum scan
            sum_all_q <= sum_all_q + thp;
            if (t_q == LAST_BIN) begin
              phase_sum_q <= 1'b0;
              t_q         <= '0;
              bsum_q      <= '0;
              w_b_q       <= '0;
              sum_b_q     <= '0;
              best_sq_q   <= '0;
              best_den_q  <= DEN_W'(1);
              best_t_q    <= '0;
            end else begin
              t_q <= t_q + 8'd1;
            end
          end else begin
            w_b_q   <= wb_n;
            sum_b_q <= sb_n;
            step_q  <= MS_TOT_SUMB;
          end
        end
        ST_MWT: begin
          if (mul_done) begin
            case (step_q)
              MS_TOT_SUMB: prod_a_q <= prod_b;
              MS_ALL_WB:   num_q <= (prod_a_q >= prod_b) ? (prod_a_q - prod_b)
                                                         : (prod_b - prod_a_q);
              MS_DEN:      den_q <= DEN_W'(mul_prod);
              MS_SQ:       sq_q <= SQ_W'(mul_prod);
              MS_LHS:      lhs_q <= mul_prod;
              MS_RHS: begin
                if (better) begin
                  best_sq_q  <= sq_q;
                  best_den_q <= den_q;
                  best_t_q   <= t_q;
                end
              end
              default: lhs_q <= lhs_q;
            endcase
            if (step_q != MS_RHS) step_q <= mstep_e'(step_q + 3'd1);
          end
        end
        ST_OUT: begin
          if (out_ready_i) count_q <= '0;
        end
        default: begin
          t_q <= t_q;
        end
      endcase

      // Advance to the next bin, start the second pass, or finish
      if (next_bin) begin
        if (t_q != LAST_BIN) begin
          t_q <= t_q + 8'd1;
        end else if (!pass2_q && adv_q) begin
          pass2_q     <= 1'b1;
          phase_sum_q <= 1'b1;
          mg_q        <= best_t_q;
          first_q     <= best_t_q;
          t_q         <= '0;
          bsum_q      <= '0;
          sum_all_q   <= '0;
        end else begin
          out_q.threshold            <= best_t_q;
          out_q.first_pass_threshold <= pass2_q ? first_q : best_t_q;
          out_q.frame_empty          <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/otsu_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on otsu_pkg for the shared project conventions.
`timescale 1ns / 1ps
`default_nettype none

module otsu_mul
  import otsu_pkg::*;
#(
  parameter int unsigned AW = 64,
  parameter int unsigned BW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [AW-1:0] a_i,
  input  wire logic [BW-1:0] b_i,
  output logic               done_o,
  output logic [AW-1:0]      prod_o
);

  logic          busy_q;
  logic [AW-1:0] a_q;
  logic [BW-1:0] b_q;
  logic [AW-1:0] acc_q;

  // Finish once every set multiplier bit has been consumed
  assign done_o = busy_q && (b_q == '0);
  assign prod_o = acc_q;

  // Load operands, then add and shift until the multiplier runs out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      a_q    <= a_i;
      b_q    <= b_i;
      acc_q  <= '0;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        if (b_q[0]) begin
          acc_q <= acc_q + a_q;
        end
        a_q <= {a_q[AW-2:0], 1'b0};
        b_q <= {1'b0, b_q[BW-1:1]};
      end
    end
  end

endmodule

`default_nettype wire
